/* rtl/gte_pkg.sv */
// Package for the triangle enumerator: sizes, status codes and FSM states.
// No dependencies.
package gte_pkg;

    localparam int MaxNodes     = 64;
    localparam int MaxNeighbors = 16;
    localparam int NodeIdxW     = $clog2(MaxNodes);
    localparam int NodeCntW     = $clog2(MaxNodes + 1);
    localparam int NbrIdxW      = $clog2(MaxNeighbors);
    localparam int NbrCntW      = $clog2(MaxNeighbors + 1);
    localparam int NbrAddrW     = NodeIdxW + NbrIdxW;

    typedef enum logic [2:0] {
        ST_EDGE_ADDED = 3'd0,
        ST_NODE_FULL  = 3'd1,
        ST_ADJ_FULL   = 3'd2,
        ST_TRI_FOUND  = 3'd3,
        ST_SCAN_DONE  = 3'd4
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE,
        S_LOOK_A,      // walk node table for a and b
        S_LOOK_WAIT,
        S_ADD_CHECK,
        S_ADD_WRA,
        S_ADD_WRB,
        S_SCAN_STEP,   // advance cursors, pick next triple
        S_RD_IDS,      // read ids of j and k
        S_RD_IDS2,
        S_RD_IDS3,
        S_RD_CNT,
        S_SRCH,        // walk one adjacency list
        S_SRCH_WAIT,
        S_SRCH_DONE,
        S_RESULT,
        S_OUT
    } t_state;

endpackage

/* rtl/graph_triangle_enumerator.sv */
// Triangle enumerator top level: node table, adjacency lists, scan sequencer.
// Depends on gte_pkg.
//
//  channel | valid   | stall   | payload
//  input   | i_valid | o_stall | i_kind, i_node_a, i_node_b
//  output  | o_valid | i_stall | o_status, o_tri_first .. o_tri_third, o_total_found
//
// An add-edge transaction walks the node table one entry at a time, reading each
// id and its count. A fetch walks node triples and searches adjacency lists entry
// by entry, all through the single read port of each memory. Reset is synchronous;
// memories
// need no clearing. o_stall is high while a transaction is in work or its
// result waits in the output register; a stalled result holds.
module graph_triangle_enumerator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_kind,
    input  logic [15:0] i_node_a,
    input  logic [15:0] i_node_b,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [15:0] o_tri_first,
    output logic [15:0] o_tri_second,
    output logic [15:0] o_tri_third,
    output logic [15:0] o_total_found
);

    localparam int NIW = gte_pkg::NodeIdxW;
    localparam int NCW = gte_pkg::NodeCntW;
    localparam int BIW = gte_pkg::NbrIdxW;
    localparam int BCW = gte_pkg::NbrCntW;
    localparam int BAW = gte_pkg::NbrAddrW;
    localparam logic [NCW-1:0] MaxN = NCW'(gte_pkg::MaxNodes);
    localparam logic [BCW-1:0] MaxB = BCW'(gte_pkg::MaxNeighbors);

    // memories
    logic [15:0]    r_ids [gte_pkg::MaxNodes];
    logic [BCW-1:0] r_cnt [gte_pkg::MaxNodes];
    logic [15:0]    r_nbr [gte_pkg::MaxNodes * gte_pkg::MaxNeighbors];

    gte_pkg::t_state r_state, n_state;

    logic [NCW-1:0] r_used, n_used;
    logic [NCW:0]   r_si, n_si, r_sj, n_sj, r_sk, n_sk;
    logic [15:0]    r_total, n_total;
    logic           r_fin, n_fin;
    logic [15:0]    r_a, n_a, r_b, n_b;
    logic [NCW-1:0] r_ptr, n_ptr;
    logic [NCW-1:0] r_ia, n_ia, r_ib, n_ib;
    logic           r_fa, n_fa, r_fb, n_fb;
    logic [BCW-1:0] r_ca, n_ca, r_cb, n_cb;
    logic [15:0]    r_idj, n_idj, r_idk, n_idk;
    logic [1:0]     r_test, n_test;      // 0: i lists j, 1: j lists k, 2: i lists k
    logic [BCW-1:0] r_m, n_m, r_lcnt, n_lcnt;
    logic [2:0]     r_ost, n_ost;
    logic           r_oval, n_oval;
    logic [15:0]    r_o1, n_o1, r_o2, n_o2, r_o3, n_o3, r_ot, n_ot;

    // memory ports
    logic [NIW-1:0] id_ra, cnt_ra;
    logic [BAW-1:0] nb_ra;
    logic [15:0]    r_id_rd, r_nb_rd;
    logic [BCW-1:0] r_cnt_rd;
    logic           id_we, cnt_we, nb_we;
    logic [NIW-1:0] id_wa, cnt_wa;
    logic [BAW-1:0] nb_wa;
    logic [15:0]    id_wd, nb_wd;
    logic [BCW-1:0] cnt_wd;

    logic           in_acc;
    logic [NCW-1:0] need, list_node;
    logic [15:0]    want;
    logic           ab_same;

    assign in_acc  = i_valid && !o_stall;
    assign o_stall = (r_state != gte_pkg::S_IDLE);
    assign ab_same = (r_a == r_b);

    // memories: one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (id_we) r_ids[id_wa] <= id_wd;
        if (cnt_we) r_cnt[cnt_wa] <= cnt_wd;
        if (nb_we) r_nbr[nb_wa] <= nb_wd;
        r_id_rd  <= r_ids[id_ra];
        r_cnt_rd <= r_cnt[cnt_ra];
        r_nb_rd  <= r_nbr[nb_ra];
    end

    // state and registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gte_pkg::S_IDLE;
            r_used  <= '0;
            r_si    <= '0;
            r_sj    <= (NCW+1)'(1);
            r_sk    <= (NCW+1)'(2);
            r_total <= '0;
            r_fin   <= 1'b0;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_si    <= n_si;
            r_sj    <= n_sj;
            r_sk    <= n_sk;
            r_total <= n_total;
            r_fin   <= n_fin;
            r_oval  <= n_oval;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a <= n_a; r_b <= n_b; r_ptr <= n_ptr;
        r_ia <= n_ia; r_ib <= n_ib; r_fa <= n_fa; r_fb <= n_fb;
        r_ca <= n_ca; r_cb <= n_cb; r_idj <= n_idj; r_idk <= n_idk;
        r_test <= n_test; r_m <= n_m; r_lcnt <= n_lcnt;
        r_ost <= n_ost; r_o1 <= n_o1; r_o2 <= n_o2; r_o3 <= n_o3; r_ot <= n_ot;
    end

    assign need = NCW'(!r_fa) + NCW'(!ab_same && !r_fb);

    // node whose list is searched and the id sought
    always_comb begin
        case (r_test)
            2'd1:    begin list_node = r_sj[NCW-1:0]; want = r_idk; end
            2'd2:    begin list_node = r_si[NCW-1:0]; want = r_idk; end
            default: begin list_node = r_si[NCW-1:0]; want = r_idj; end
        endcase
    end

    // sequencer
    always_comb begin
        n_state = r_state; n_used = r_used; n_si = r_si; n_sj = r_sj; n_sk = r_sk;
        n_total = r_total; n_fin = r_fin; n_a = r_a; n_b = r_b;
        n_ptr = r_ptr; n_ia = r_ia; n_ib = r_ib; n_fa = r_fa; n_fb = r_fb;
        n_ca = r_ca; n_cb = r_cb; n_idj = r_idj; n_idk = r_idk;
        n_test = r_test; n_m = r_m; n_lcnt = r_lcnt;
        n_ost = r_ost; n_oval = r_oval; n_o1 = r_o1; n_o2 = r_o2; n_o3 = r_o3;
        n_ot = r_ot;
        id_ra = r_ptr[NIW-1:0]; cnt_ra = r_ptr[NIW-1:0];
        nb_ra = {list_node[NIW-1:0], r_m[BIW-1:0]};
        id_we = 1'b0; cnt_we = 1'b0; nb_we = 1'b0;
        id_wa = r_ia[NIW-1:0]; cnt_wa = r_ia[NIW-1:0]; nb_wa = '0;
        id_wd = r_a; nb_wd = r_b; cnt_wd = '0;

        if (r_oval && !i_stall) n_oval = 1'b0;

        case (r_state)
            gte_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_a = i_node_a; n_b = i_node_b;
                    n_ptr = '0; n_fa = 1'b0; n_fb = 1'b0;
                    n_o1 = '0; n_o2 = '0; n_o3 = '0; n_ot = '0;
                    n_state = i_kind ? gte_pkg::S_SCAN_STEP : gte_pkg::S_LOOK_A;
                    if (i_kind && r_fin) n_state = gte_pkg::S_RESULT;
                end
            end
            // read one table entry and its count; S_LOOK_WAIT compares it with a and b
            gte_pkg::S_LOOK_A: begin
                n_state = (r_ptr < r_used) ? gte_pkg::S_LOOK_WAIT : gte_pkg::S_ADD_CHECK;
            end
            gte_pkg::S_LOOK_WAIT: begin
                if (!r_fa && r_id_rd == r_a) begin
                    n_fa = 1'b1; n_ia = r_ptr; n_ca = r_cnt_rd;
                end
                if (!r_fb && r_id_rd == r_b) begin
                    n_fb = 1'b1; n_ib = r_ptr; n_cb = r_cnt_rd;
                end
                n_ptr = r_ptr + 1'b1;
                n_state = gte_pkg::S_LOOK_A;
            end
            gte_pkg::S_ADD_CHECK: begin
                n_si = '0; n_sj = (NCW+1)'(1); n_sk = (NCW+1)'(2);
                n_total = '0; n_fin = 1'b0;
                n_state = gte_pkg::S_OUT;
                if ({1'b0, r_used} + {1'b0, need} > {1'b0, MaxN}) begin
                    n_ost = 3'(gte_pkg::ST_NODE_FULL);
                end else begin
                    if (!r_fa) begin n_ia = r_used; n_ca = '0; end
                    if (ab_same) begin
                        n_ib = r_fa ? r_ia : r_used;
                        n_cb = r_fa ? r_ca : '0;
                    end else if (!r_fb) begin
                        n_ib = r_used + NCW'(!r_fa);
                        n_cb = '0;
                    end
                    n_ost = 3'(gte_pkg::ST_ADJ_FULL);
                    if (ab_same) begin
                        if ({1'b0, (r_fa ? r_ca : BCW'(0))} + 2 <= {1'b0, MaxB}) begin
                            n_ost = 3'(gte_pkg::ST_EDGE_ADDED);
                            n_state = gte_pkg::S_ADD_WRA;
                        end
                    end else if ((r_fa ? r_ca : BCW'(0)) < MaxB &&
                                 (r_fb ? r_cb : BCW'(0)) < MaxB) begin
                        n_ost = 3'(gte_pkg::ST_EDGE_ADDED);
                        n_state = gte_pkg::S_ADD_WRA;
                    end
                    if (n_state == gte_pkg::S_ADD_WRA) n_used = r_used + need;
                end
            end
            // append b to a's list
            gte_pkg::S_ADD_WRA: begin
                id_we = 1'b1; id_wa = r_ia[NIW-1:0]; id_wd = r_a;
                nb_we = 1'b1; nb_wa = {r_ia[NIW-1:0], r_ca[BIW-1:0]}; nb_wd = r_b;
                cnt_we = 1'b1; cnt_wa = r_ia[NIW-1:0]; cnt_wd = r_ca + 1'b1;
                if (ab_same) n_cb = r_ca + 1'b1;
                n_state = gte_pkg::S_ADD_WRB;
            end
            // append a to b's list
            gte_pkg::S_ADD_WRB: begin
                id_we = 1'b1; id_wa = r_ib[NIW-1:0]; id_wd = r_b;
                nb_we = 1'b1; nb_wa = {r_ib[NIW-1:0], r_cb[BIW-1:0]}; nb_wd = r_a;
                cnt_we = 1'b1; cnt_wa = r_ib[NIW-1:0]; cnt_wd = r_cb + 1'b1;
                n_state = gte_pkg::S_OUT;
            end
            // normalize cursors to the next candidate triple, or end the scan when none is left
            gte_pkg::S_SCAN_STEP: begin
                if (!(r_si + 2 < {1'b0, r_used})) begin
                    n_fin = 1'b1;
                    n_state = gte_pkg::S_RESULT;
                end else if (r_sj + 1 >= {1'b0, r_used}) begin
                    n_si = r_si + 1'b1;
                    n_sj = (NCW+1)'(r_si + 2);
                    n_sk = (NCW+1)'(r_si + 3);
                end else if (r_sk >= {1'b0, r_used}) begin
                    n_sj = r_sj + 1'b1;
                    n_sk = (NCW+1)'(r_sj + 2);
                end else begin
                    n_state = gte_pkg::S_RD_IDS;
                end
            end
            gte_pkg::S_RD_IDS: begin
                id_ra = r_sj[NIW-1:0];
                n_state = gte_pkg::S_RD_IDS2;
            end
            gte_pkg::S_RD_IDS2: begin
                id_ra = r_sk[NIW-1:0];
                n_idj = r_id_rd;
                n_state = gte_pkg::S_RD_IDS3;
            end
            gte_pkg::S_RD_IDS3: begin
                id_ra = r_si[NIW-1:0];
                n_idk = r_id_rd;
                n_test = 2'd0;
                n_state = gte_pkg::S_RD_CNT;
            end
            gte_pkg::S_RD_CNT: begin
                cnt_ra = list_node[NIW-1:0];
                n_m = '0;
                n_state = gte_pkg::S_SRCH;
            end
            gte_pkg::S_SRCH: begin
                n_lcnt = (r_m == '0) ? r_cnt_rd : r_lcnt;
                if (r_m >= ((r_m == '0) ? r_cnt_rd : r_lcnt)) begin
                    // list exhausted: not adjacent, try next k
                    n_sk = r_sk + 1'b1;
                    n_state = gte_pkg::S_SCAN_STEP;
                end else begin
                    n_state = gte_pkg::S_SRCH_WAIT;
                end
            end
            gte_pkg::S_SRCH_WAIT: begin
                n_state = gte_pkg::S_SRCH_DONE;
            end
            gte_pkg::S_SRCH_DONE: begin
                if (r_nb_rd == want) begin
                    if (r_test == 2'd2) begin
                        if (r_total != 16'hFFFF) n_total = r_total + 1'b1;
                        n_sk = r_sk + 1'b1;
                        n_state = gte_pkg::S_RD_IDS3;
                        n_test = 2'd3;
                    end else begin
                        n_test = r_test + 1'b1;
                        n_state = gte_pkg::S_RD_CNT;
                    end
                end else begin
                    n_m = r_m + 1'b1;
                    n_state = gte_pkg::S_SRCH;
                end
                if (r_test == 2'd2 && r_nb_rd == want) begin
                    // found: id of i arrives next cycle through S_RESULT
                    id_ra = r_si[NIW-1:0];
                    n_state = gte_pkg::S_RESULT;
                    n_ost = 3'(gte_pkg::ST_TRI_FOUND);
                    n_test = 2'd3;
                end
            end
            gte_pkg::S_RESULT: begin
                if (r_test == 2'd3 && !r_fin) begin
                    n_o1 = r_id_rd; n_o2 = r_idj; n_o3 = r_idk;
                    n_ost = 3'(gte_pkg::ST_TRI_FOUND);
                end else begin
                    n_ost = 3'(gte_pkg::ST_SCAN_DONE);
                end
                n_ot = n_total;
                n_test = 2'd0;
                n_state = gte_pkg::S_OUT;
            end
            // hold result until taken
            gte_pkg::S_OUT: begin
                if (!r_oval) n_oval = 1'b1;
                else if (!i_stall) n_state = gte_pkg::S_IDLE;
                if (r_oval && !i_stall) n_oval = 1'b0;
            end
            default: n_state = gte_pkg::S_IDLE;
        endcase
    end

    assign o_valid       = r_oval;
    assign o_status      = r_ost;
    assign o_tri_first   = r_o1;
    assign o_tri_second  = r_o2;
    assign o_tri_third   = r_o3;
    assign o_total_found = r_ot;

    // node count never exceeds table size
    a_used_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= MaxN) else $error("node count over table size");
    // result is only presented from the output state
    a_oval_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oval |-> r_state == gte_pkg::S_OUT) else $error("result outside output state");
    // stalled result holds its status
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oval && i_stall |=> $stable(r_ost)) else $error("result changed while stalled");

endmodule
